// File: rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared definitions for the two-class priority queue
// Sizes, request and status codes, and the record and write-port types
// used by the queue controller and its record store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH  = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_W        = 8;
  localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  // field widths fixed by the item format
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // reset value of the threshold register
  localparam logic [KEY_W-1:0] THRESH_RESET = KEY_W'(65);

  // request codes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_PRIO = 2'd1;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] data;
  } record_t;

  // write port of the record store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    record_t          rec;
  } store_wr_t;

endpackage

`default_nettype wire

// File: rtl/tcpq_req_if.sv
// ----------------------------------------------------------------------------
// tcpq_req_if: request channel of the priority queue
// Valid/ready channel carrying one request item: op, age and payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [tcpq_pkg::OP_W-1:0]            op;
  logic [tcpq_pkg::KEY_W-1:0]           age;
  logic [tcpq_pkg::PAYLOAD_BITS-1:0]    payload;

  modport source (output valid, output op, output age, output payload, input ready);
  modport sink   (input valid, input op, input age, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/tcpq_rsp_if.sv
// ----------------------------------------------------------------------------
// tcpq_rsp_if: response channel of the priority queue
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [tcpq_pkg::STATUS_W-1:0]        status;
  logic [tcpq_pkg::KEY_W-1:0]           out_age;
  logic [tcpq_pkg::PAYLOAD_BITS-1:0]    out_payload;
  logic [tcpq_pkg::CNT_W-1:0]           occupancy;

  modport source (output valid, output status, output out_age, output out_payload,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_age, input out_payload,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/tcpq_store.sv
// ----------------------------------------------------------------------------
// tcpq_store: record store of the priority queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpq_store (
  input  logic                        clk,
  input  tcpq_pkg::store_wr_t         wr,
  input  logic [tcpq_pkg::IDX_W-1:0]  rd_addr,
  output tcpq_pkg::record_t           rd_rec
);
  import tcpq_pkg::*;

  record_t mem [QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.rec;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_rec <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue: bounded queue with sorted priority insertion
// Controller that sequences compares and record moves through one store.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready): op, age, payload. Op 0 appends at the tail,
//   op 1 appends too unless age is at or above the threshold, in which case
//   the record goes before the first stored entry with a key not above its
//   own. Op 2 removes the head. rsp channel returns one item per request:
//   status, out_age, out_payload (zero unless a head was removed) and the
//   occupancy after the request.
//   cfg_we/cfg_data write the 8-bit priority threshold (reset value 65).
// Timing:
//   Records live in a circular store with one read and one write port; each
//   entry is compared or moved by a read step and then a compare or write
//   step. A flagged or unused request goes straight to its result; a plain
//   enqueue places its record first, a dequeue reads the head, and a jumping
//   priority enqueue scans and shifts entries before placing. One request is
//   in work at a time; req.ready is high only while idle.
// Reset: rst (synchronous) empties the queue and drops any pending result.
// Stall: a finished result waits in the output register; the next request
//   may be taken meanwhile, but its result waits until the first is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tcpq_pkg::KEY_W-1:0]  cfg_data,
  tcpq_req_if.sink                    req,
  tcpq_rsp_if.source                  rsp
);
  import tcpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DEQ_RD,
    S_DEQ_DATA,
    S_DONE
  } state_t;

  state_t                  state;
  logic [KEY_W-1:0]        thresh;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        pos;
  logic [CNT_W-1:0]        idx;
  logic [KEY_W-1:0]        cur_key;
  logic [PAYLOAD_BITS-1:0] cur_data;
  logic [STATUS_W-1:0]     res_status;
  logic [KEY_W-1:0]        res_age;
  logic [PAYLOAD_BITS-1:0] res_payload;

  logic [STATUS_W-1:0]     rsp_status;
  logic [KEY_W-1:0]        rsp_age;
  logic [PAYLOAD_BITS-1:0] rsp_payload;
  logic [CNT_W-1:0]        rsp_occ;
  logic                    rsp_valid;

  store_wr_t               st_wr;
  logic [IDX_W-1:0]        st_rd_addr;
  record_t                 st_rd_rec;
  logic                    out_free;

  // physical slot of a logical position counted from the head
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(h) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  tcpq_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (st_rd_addr),
    .rd_rec  (st_rd_rec)
  );

  // store access per sequencer step
  always_comb begin
    st_rd_addr = head;
    st_wr      = '0;
    case (state)
      S_SCAN_RD:  st_rd_addr = slot(head, pos);
      S_SHIFT_RD: st_rd_addr = slot(head, idx - CNT_W'(1));
      S_SHIFT_WR: begin
        st_wr.en  = 1'b1;
        st_wr.addr = slot(head, idx);
        st_wr.rec = st_rd_rec;
      end
      S_PLACE: begin
        st_wr.en       = 1'b1;
        st_wr.addr     = slot(head, pos);
        st_wr.rec.key  = cur_key;
        st_wr.rec.data = cur_data;
      end
      default: st_rd_addr = head;
    endcase
  end

  assign out_free        = !rsp_valid || rsp.ready;
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.out_age     = rsp_age;
  assign rsp.out_payload = rsp_payload;
  assign rsp.occupancy   = rsp_occ;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the done step reloads the output register itself
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_key     <= req.age;
            cur_data    <= req.payload;
            res_age     <= '0;
            res_payload <= '0;
            case (req.op)
              OP_ENQ, OP_PRIO: begin
                if (count == CNT_W'(QUEUE_DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (req.op == OP_ENQ || req.age < thresh) begin
                  res_status <= ST_DONE;
                  pos        <= count;
                  state      <= S_PLACE;
                end else begin
                  res_status <= ST_DONE;
                  pos        <= '0;
                  state      <= S_SCAN_RD;
                end
              end
              OP_DEQ: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_DONE;
                  state      <= S_DEQ_RD;
                end
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
            endcase
          end
        end
        // walk from the head until a key not above the new one
        S_SCAN_RD: begin
          if (pos == count) begin
            idx   <= count;
            state <= S_SHIFT_RD;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (st_rd_rec.key > cur_key) begin
            pos   <= pos + CNT_W'(1);
            state <= S_SCAN_RD;
          end else begin
            idx   <= count;
            state <= S_SHIFT_RD;
          end
        end
        // move entries back one slot, tail first
        S_SHIFT_RD: begin
          if (idx == pos) begin
            state <= S_PLACE;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx - CNT_W'(1);
          state <= S_SHIFT_RD;
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        // remove the head
        S_DEQ_RD: state <= S_DEQ_DATA;
        S_DEQ_DATA: begin
          res_age     <= st_rd_rec.key;
          res_payload <= st_rd_rec.data;
          head        <= slot(head, CNT_W'(1));
          count       <= count - CNT_W'(1);
          state       <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            rsp_status  <= res_status;
            rsp_age     <= res_age;
            rsp_payload <= res_payload;
            rsp_occ     <= count;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
